// ----- src/modular_exponentiation_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Short forms of clocked implications, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_exponentiation: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define MX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_exponentiation: next-cycle check failed");

`endif

// ----- src/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths, constants and the sequencer state type of the modular exponentiation
// block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [WIDTH:0]   wide_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam word_t WORD_ONE = word_t'(1);
    localparam cnt_t  CNT_ONE  = cnt_t'(1);
    localparam cnt_t  CNT_LAST = cnt_t'(WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

endpackage

// ----- src/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary square and multiply, with one bit-serial modular
// multiplier shared by the base reduction, the multiplies and the squares.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes base, exponent and modulus.
//   Output channel (out_valid / out_stall) returns residue and modulus_zero.
//   One request is worked on at a time; in_stall is high while it runs.
//   The shared multiplier consumes one multiplier bit per cycle. A request
//   first reduces the base, then for each exponent bit up to its highest set
//   bit runs a check, a multiply when the bit is set, and a square (the square
//   after the top set bit is skipped).
//   A zero modulus goes straight to the done state with modulus_zero set, residue 0.
//   The result sits in an output register; the next request is taken while it
//   waits. A finished request waits in its last state while the output
//   register is full and stalled.
//   Reset (rst_n low) returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  modexp_pkg::word_t        base,
    input  modexp_pkg::word_t        exponent,
    input  modexp_pkg::word_t        modulus,
    output logic                     out_valid,
    input  logic                     out_stall,
    output modexp_pkg::word_t        residue,
    output logic                     modulus_zero
);

    modexp_pkg::state_t state_reg, state_next;
    logic               out_valid_reg, out_valid_next;

    modexp_pkg::cnt_t   cnt_reg, cnt_next;
    modexp_pkg::word_t  acc_reg, acc_next;
    modexp_pkg::word_t  x_reg, x_next;
    modexp_pkg::word_t  y_reg, y_next;
    modexp_pkg::word_t  prod_reg, prod_next;
    modexp_pkg::word_t  sq_reg, sq_next;
    modexp_pkg::word_t  exp_reg, exp_next;
    modexp_pkg::word_t  mod_reg, mod_next;
    logic               mz_reg, mz_next;
    modexp_pkg::word_t  res_reg, res_next;
    logic               omz_reg, omz_next;

    modexp_pkg::wide_t  dbl;
    modexp_pkg::wide_t  dbl_red;
    modexp_pkg::wide_t  sum;
    modexp_pkg::wide_t  sum_red;
    modexp_pkg::word_t  step;
    logic               mul_last;

    logic               req_take;
    logic               mul_busy;
    logic               done_busy;

    // One multiplier bit: acc = 2*acc mod m, then add x mod m if the bit is set.
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, mod_reg}) ? (dbl - {1'b0, mod_reg}) : dbl;
        sum      = {1'b0, dbl_red[modexp_pkg::WIDTH-1:0]} + {1'b0, x_reg};
        sum_red  = (sum >= {1'b0, mod_reg}) ? (sum - {1'b0, mod_reg}) : sum;
        step     = y_reg[modexp_pkg::WIDTH-1] ? sum_red[modexp_pkg::WIDTH-1:0]
                                              : dbl_red[modexp_pkg::WIDTH-1:0];
        mul_last = (cnt_reg == modexp_pkg::CNT_LAST);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        mz_next        = mz_reg;
        res_next       = res_reg;
        omz_next       = omz_reg;
        in_stall       = 1'b1;

        // drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    exp_next = exponent;
                    mod_next = modulus;
                    if (modulus == '0)
                    begin
                        prod_next  = '0;
                        mz_next    = 1'b1;
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        // base mod m is (1 mod m) times base
                        mz_next    = 1'b0;
                        acc_next   = '0;
                        cnt_next   = '0;
                        x_next     = (modulus == modexp_pkg::WORD_ONE) ? '0
                                                                       : modexp_pkg::WORD_ONE;
                        y_next     = base;
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end

            modexp_pkg::ST_REDUCE:
            begin
                acc_next = step;
                y_next   = {y_reg[modexp_pkg::WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + modexp_pkg::CNT_ONE;
                if (mul_last)
                begin
                    sq_next    = step;
                    prod_next  = x_reg;
                    state_next = modexp_pkg::ST_CHECK;
                end
            end

            modexp_pkg::ST_CHECK:
            begin
                acc_next = '0;
                cnt_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = modexp_pkg::ST_DONE;
                end
                else if (exp_reg[0])
                begin
                    x_next     = prod_reg;
                    y_next     = sq_reg;
                    state_next = modexp_pkg::ST_MUL;
                end
                else
                begin
                    x_next     = sq_reg;
                    y_next     = sq_reg;
                    state_next = modexp_pkg::ST_SQR;
                end
            end

            modexp_pkg::ST_MUL:
            begin
                acc_next = step;
                y_next   = {y_reg[modexp_pkg::WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + modexp_pkg::CNT_ONE;
                if (mul_last)
                begin
                    prod_next = step;
                    // skip the square after the top set bit
                    if (exp_reg[modexp_pkg::WIDTH-1:1] == '0)
                    begin
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        x_next     = sq_reg;
                        y_next     = sq_reg;
                        state_next = modexp_pkg::ST_SQR;
                    end
                end
            end

            modexp_pkg::ST_SQR:
            begin
                acc_next = step;
                y_next   = {y_reg[modexp_pkg::WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + modexp_pkg::CNT_ONE;
                if (mul_last)
                begin
                    sq_next    = step;
                    exp_next   = {1'b0, exp_reg[modexp_pkg::WIDTH-1:1]};
                    state_next = modexp_pkg::ST_CHECK;
                end
            end

            modexp_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    res_next       = prod_reg;
                    omz_next       = mz_reg;
                    out_valid_next = 1'b1;
                    state_next     = modexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        mz_reg   <= mz_next;
        res_reg  <= res_next;
        omz_reg  <= omz_next;
    end

    assign out_valid    = out_valid_reg;
    assign residue      = res_reg;
    assign modulus_zero = omz_reg;

    assign req_take  = in_valid && !in_stall;
    assign mul_busy  = (state_reg == modexp_pkg::ST_REDUCE) || (state_reg == modexp_pkg::ST_MUL)
                       || (state_reg == modexp_pkg::ST_SQR);
    assign done_busy = (state_reg == modexp_pkg::ST_DONE);

    `MX_ASSERT_NEXT(a_zero_mod_flag, req_take && (modulus == '0), mz_reg && done_busy)
    `MX_ASSERT_SAME(a_acc_reduced, mul_busy, acc_reg < mod_reg)
    `MX_ASSERT_SAME(a_result_reduced, done_busy && !mz_reg, prod_reg < mod_reg)
    `MX_ASSERT_NEXT(a_done_waits, done_busy && out_valid_reg && out_stall, done_busy && out_valid_reg)

endmodule
